>>> rtl/meq_pkg.sv
// Package for the mouse event qualifier: shared types and codes.
// No dependencies; used by every module of the block.
package meq_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned BTN_W   = 3;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned DIM_W   = 15;
  localparam int unsigned EDGE_W  = 4;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

  localparam logic [DIM_W-1:0] SCREEN_WIDTH_RST  = 15'd1024;
  localparam logic [DIM_W-1:0] SCREEN_HEIGHT_RST = 15'd768;

  typedef enum logic [1:0] {
    LEFT_HOLD    = 2'd0,
    LEFT_DRAG    = 2'd1,
    LEFT_CLICK   = 2'd2,
    LEFT_RELEASE = 2'd3
  } left_status_t;

  localparam logic [1:0] WHEEL_NEG  = 2'd0;
  localparam logic [1:0] WHEEL_POS  = 2'd1;
  localparam logic [1:0] WHEEL_NONE = 2'd2;

  localparam int unsigned EDGE_LEFT  = 0;
  localparam int unsigned EDGE_RIGHT = 1;
  localparam int unsigned EDGE_UP    = 2;
  localparam int unsigned EDGE_DOWN  = 3;

  // pipeline enables from the handshake control
  typedef struct packed {
    logic load_in;
    logic step;
  } meq_ctrl_t;

  typedef struct packed {
    logic [EDGE_W-1:0] edge_scroll;
    logic [BTN_W-1:0]  button_press;
    logic [BTN_W-1:0]  button_release;
    logic              activity;
    left_status_t      left_status;
    logic [TIME_W-1:0] left_press_time;
    logic [TIME_W-1:0] idle_ms;
    logic [1:0]        wheel_dir;
  } meq_result_t;

endpackage

>>> rtl/meq_ctrl.sv
// Handshake control: valid bits of the input and result registers.
// Depends on meq_pkg.
module meq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output meq_pkg::meq_ctrl_t ctrl
);

  logic s1_valid;
  logic s1_valid_next;
  logic out_valid_next;
  logic out_can;
  logic s1_can;

  always_comb begin
    out_can      = !out_valid || !out_stall;
    s1_can       = !s1_valid || out_can;
    in_stall     = !s1_can;
    ctrl.load_in = in_valid && s1_can;
    ctrl.step    = s1_valid && out_can;
    if (ctrl.load_in) begin
      s1_valid_next = 1'b1;
    end else if (ctrl.step) begin
      s1_valid_next = 1'b0;
    end else begin
      s1_valid_next = s1_valid;
    end
    if (ctrl.step) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= s1_valid_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

>>> rtl/meq_ring.sv
// Position history ring: write-only store of moved pointer positions.
// Depends on meq_pkg for coordinate width.
module meq_ring #(
  parameter int unsigned DEPTH = 10,
  parameter int unsigned PTR_W = 4
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [PTR_W-1:0]             addr,
  input  logic [2*meq_pkg::COORD_W-1:0] data
);

  logic [2*meq_pkg::COORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= data;
    end
  end

endmodule

>>> rtl/meq_core.sv
// Sample register, qualifier state, result logic and result register.
// Depends on meq_pkg; drives the write side of meq_ring.
module meq_core #(
  parameter int unsigned HISTORY_DEPTH = 10,
  parameter int unsigned PTR_W = 4,
  parameter int unsigned SLOT_W = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  meq_pkg::meq_ctrl_t                ctrl,
  input  logic [meq_pkg::DIM_W-1:0]         screen_width,
  input  logic [meq_pkg::DIM_W-1:0]         screen_height,
  input  logic signed [meq_pkg::COORD_W-1:0] window_x,
  input  logic signed [meq_pkg::COORD_W-1:0] window_y,
  input  logic signed [meq_pkg::COORD_W-1:0] cursor_x,
  input  logic signed [meq_pkg::COORD_W-1:0] cursor_y,
  input  logic [meq_pkg::BTN_W-1:0]         buttons,
  input  logic signed [meq_pkg::COORD_W-1:0] wheel_delta,
  input  logic [meq_pkg::TIME_W-1:0]        now_ms,
  output meq_pkg::meq_result_t              result,
  output logic [SLOT_W-1:0]                 history_slot,
  output logic                              ring_we,
  output logic [PTR_W-1:0]                  ring_addr,
  output logic [2*meq_pkg::COORD_W-1:0]     ring_data
);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HISTORY_DEPTH - 1);

  // sample register
  logic signed [meq_pkg::COORD_W-1:0] s_wx, s_wy, s_cx, s_cy, s_wheel;
  logic [meq_pkg::BTN_W-1:0]          s_btn;
  logic [meq_pkg::TIME_W-1:0]         s_now;

  // qualifier state
  logic [meq_pkg::COORD_W-1:0] last_x, last_y, anchor_x, anchor_y;
  logic [meq_pkg::BTN_W-1:0]   last_buttons;
  meq_pkg::left_status_t       press_status;
  logic [meq_pkg::TIME_W-1:0]  press_time, idle_since;
  logic [PTR_W-1:0]            ring_pointer;

  logic [meq_pkg::COORD_W-1:0] anchor_x_next, anchor_y_next;
  meq_pkg::left_status_t       press_status_next;
  logic [meq_pkg::TIME_W-1:0]  press_time_next, idle_since_next;
  logic [PTR_W-1:0]            ring_pointer_next;

  logic                          moved;
  logic                          at_anchor;
  logic [meq_pkg::BTN_W-1:0]     changed;
  logic signed [meq_pkg::COORD_W:0] cx_ext, cy_ext, right_edge, bottom_edge;
  meq_pkg::meq_result_t          res;
  logic [SLOT_W-1:0]             slot;

  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      s_wx    <= window_x;
      s_wy    <= window_y;
      s_cx    <= cursor_x;
      s_cy    <= cursor_y;
      s_btn   <= buttons;
      s_wheel <= wheel_delta;
      s_now   <= now_ms;
    end
  end

  always_comb begin
    moved   = (s_wx != last_x) || (s_wy != last_y);
    changed = s_btn ^ last_buttons;

    cx_ext      = (meq_pkg::COORD_W+1)'(s_cx);
    cy_ext      = (meq_pkg::COORD_W+1)'(s_cy);
    right_edge  = $signed({2'b00, screen_width}) - 17'sd1;
    bottom_edge = $signed({2'b00, screen_height}) - 17'sd1;

    anchor_x_next     = anchor_x;
    anchor_y_next     = anchor_y;
    press_time_next   = press_time;
    press_status_next = press_status;
    at_anchor = (anchor_x == s_wx) && (anchor_y == s_wy);
    if (s_btn[0]) begin
      if (!last_buttons[0]) begin
        press_status_next = meq_pkg::LEFT_HOLD;
        press_time_next   = s_now;
        anchor_x_next     = s_wx;
        anchor_y_next     = s_wy;
      end else if (!at_anchor) begin
        press_status_next = meq_pkg::LEFT_DRAG;
      end
    end else if (at_anchor && press_status != meq_pkg::LEFT_DRAG) begin
      press_status_next = meq_pkg::LEFT_CLICK;
    end else begin
      press_status_next = meq_pkg::LEFT_RELEASE;
    end

    res.edge_scroll[meq_pkg::EDGE_LEFT]  = cx_ext <= 17'sd0;
    res.edge_scroll[meq_pkg::EDGE_RIGHT] = cx_ext >= right_edge;
    res.edge_scroll[meq_pkg::EDGE_UP]    = cy_ext <= 17'sd0;
    res.edge_scroll[meq_pkg::EDGE_DOWN]  = cy_ext >= bottom_edge;
    res.button_press    = changed & s_btn;
    res.button_release  = changed & last_buttons;
    res.activity        = moved || (changed != '0);
    res.left_status     = press_status_next;
    res.left_press_time = (press_status_next == meq_pkg::LEFT_HOLD) ? press_time_next : '0;
    res.idle_ms         = res.activity ? '0 : s_now - idle_since;
    idle_since_next     = res.activity ? s_now : idle_since;
    if (s_wheel < 0) begin
      res.wheel_dir = meq_pkg::WHEEL_NEG;
    end else if (s_wheel > 0) begin
      res.wheel_dir = meq_pkg::WHEEL_POS;
    end else begin
      res.wheel_dir = meq_pkg::WHEEL_NONE;
    end

    if (!moved) begin
      ring_pointer_next = ring_pointer;
    end else if (ring_pointer >= PTR_LAST) begin
      ring_pointer_next = '0;
    end else begin
      ring_pointer_next = ring_pointer + 1'b1;
    end
    slot = moved ? SLOT_W'(ring_pointer) : '0;

    ring_we   = ctrl.step && moved;
    ring_addr = ring_pointer;
    ring_data = {s_wy, s_wx};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_x       <= '0;
      last_y       <= '0;
      last_buttons <= '0;
      anchor_x     <= '0;
      anchor_y     <= '0;
      press_status <= meq_pkg::LEFT_RELEASE;
      press_time   <= '0;
      idle_since   <= '0;
      ring_pointer <= '0;
    end else if (ctrl.step) begin
      last_x       <= s_wx;
      last_y       <= s_wy;
      last_buttons <= s_btn;
      anchor_x     <= anchor_x_next;
      anchor_y     <= anchor_y_next;
      press_status <= press_status_next;
      press_time   <= press_time_next;
      idle_since   <= idle_since_next;
      ring_pointer <= ring_pointer_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      result       <= res;
      history_slot <= slot;
    end
  end

endmodule

>>> rtl/mouse_event_qualifier.sv
// 2 register stages: an accepted sample goes into the sample register, then into the result register.
// Throughput: one sample per cycle; the input stalls only while both the
// sample register and the result register hold and the output is stalled.
// Reset (rst, synchronous): empties both stages, returns the qualifier
// state to released/zero and the screen size registers to 1024 x 768.
// Top level; depends on meq_pkg, meq_ctrl, meq_core and meq_ring.
module mouse_event_qualifier #(
  parameter int unsigned HISTORY_DEPTH = 10,
  localparam int unsigned PTR_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1,
  localparam int unsigned SLOT_W = (PTR_W > 4) ? PTR_W : 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                write_enable,
  input  logic [meq_pkg::CFG_IDX_W-1:0]       write_index,
  input  logic [meq_pkg::DIM_W-1:0]           write_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [meq_pkg::COORD_W-1:0]  window_x,
  input  logic signed [meq_pkg::COORD_W-1:0]  window_y,
  input  logic signed [meq_pkg::COORD_W-1:0]  cursor_x,
  input  logic signed [meq_pkg::COORD_W-1:0]  cursor_y,
  input  logic [meq_pkg::BTN_W-1:0]           buttons,
  input  logic signed [meq_pkg::COORD_W-1:0]  wheel_delta,
  input  logic [meq_pkg::TIME_W-1:0]          now_ms,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [meq_pkg::EDGE_W-1:0]          edge_scroll,
  output logic [meq_pkg::BTN_W-1:0]           button_press,
  output logic [meq_pkg::BTN_W-1:0]           button_release,
  output logic                                activity,
  output logic [1:0]                          left_status,
  output logic [meq_pkg::TIME_W-1:0]          left_press_time,
  output logic [meq_pkg::TIME_W-1:0]          idle_ms,
  output logic [1:0]                          wheel_dir,
  output logic [SLOT_W-1:0]                   history_slot
);

  logic [meq_pkg::DIM_W-1:0] screen_width;
  logic [meq_pkg::DIM_W-1:0] screen_height;

  meq_pkg::meq_ctrl_t            ctrl;
  meq_pkg::meq_result_t          result;
  logic                          ring_we;
  logic [PTR_W-1:0]              ring_addr;
  logic [2*meq_pkg::COORD_W-1:0] ring_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= meq_pkg::SCREEN_WIDTH_RST;
      screen_height <= meq_pkg::SCREEN_HEIGHT_RST;
    end else if (write_enable) begin
      case (write_index)
        meq_pkg::REG_SCREEN_WIDTH:  screen_width  <= write_data;
        meq_pkg::REG_SCREEN_HEIGHT: screen_height <= write_data;
        default: ;
      endcase
    end
  end

  meq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctrl      (ctrl)
  );

  meq_core #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .PTR_W         (PTR_W),
    .SLOT_W        (SLOT_W)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .window_x      (window_x),
    .window_y      (window_y),
    .cursor_x      (cursor_x),
    .cursor_y      (cursor_y),
    .buttons       (buttons),
    .wheel_delta   (wheel_delta),
    .now_ms        (now_ms),
    .result        (result),
    .history_slot  (history_slot),
    .ring_we       (ring_we),
    .ring_addr     (ring_addr),
    .ring_data     (ring_data)
  );

  meq_ring #(
    .DEPTH (HISTORY_DEPTH),
    .PTR_W (PTR_W)
  ) u_ring (
    .clk  (clk),
    .we   (ring_we),
    .addr (ring_addr),
    .data (ring_data)
  );

  assign edge_scroll     = result.edge_scroll;
  assign button_press    = result.button_press;
  assign button_release  = result.button_release;
  assign activity        = result.activity;
  assign left_status     = result.left_status;
  assign left_press_time = result.left_press_time;
  assign idle_ms         = result.idle_ms;
  assign wheel_dir       = result.wheel_dir;

endmodule

>>> rtl/meq_checker.sv
// Port-level checks of mouse_event_qualifier, bound to the top level.
// Depends on meq_pkg.
module meq_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [meq_pkg::BTN_W-1:0]    button_press,
  input logic [meq_pkg::BTN_W-1:0]    button_release,
  input logic                         activity,
  input logic [1:0]                   left_status,
  input logic [meq_pkg::TIME_W-1:0]   left_press_time,
  input logic [meq_pkg::TIME_W-1:0]   idle_ms
);

  // an empty result register never holds off the input
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

  // a stalled transaction stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(left_status) && $stable(idle_ms))
    else $error("stalled result changed");

  // button edges imply activity, and activity clears the idle time
  a_edges_active: assert property (@(posedge clk) disable iff (rst)
    out_valid && (button_press != '0 || button_release != '0) |-> activity && idle_ms == '0)
    else $error("button edge without activity");

  a_press_time_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && left_status != meq_pkg::LEFT_HOLD |-> left_press_time == '0)
    else $error("press time shown outside hold");

endmodule

bind mouse_event_qualifier meq_checker u_meq_checker (
  .clk             (clk),
  .rst             (rst),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .button_press    (button_press),
  .button_release  (button_release),
  .activity        (activity),
  .left_status     (left_status),
  .left_press_time (left_press_time),
  .idle_ms         (idle_ms)
);
